// File: rtl/icmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare statistics: shared types and constants
// Field widths, configuration register indexes and the records passed
// between the lane, accumulator, verdict and output queue stages.
// ----------------------------------------------------------------------------
package icmp_pkg;

	localparam int CHANNELS   = 4;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int TOL_W      = 8;
	localparam int RATIO_W    = 17;
	localparam int MEAN_W     = 16;
	localparam int CNT_W      = 21;
	localparam int ERR_W      = 31;
	localparam int ERR_OUT_W  = 30;
	localparam int SUM_W      = 10;
	localparam int AREA_W     = 2 * DIM_W;
	localparam int RATIO_PROD_W = RATIO_W + AREA_W;
	localparam int MEAN_PROD_W  = MEAN_W + AREA_W;
	localparam int FRAC_RATIO_W = 16;
	localparam int FRAC_MEAN_W  = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_EXP_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEAN   = 3'd6;

	localparam int S_TDATA_W = 2 * CHANNELS * PIX_W;
	localparam int M_TDATA_W = 88;

	typedef struct packed {
		logic [DIM_W-1:0]   expected_width;
		logic [DIM_W-1:0]   expected_height;
		logic [DIM_W-1:0]   actual_width;
		logic [DIM_W-1:0]   actual_height;
		logic [TOL_W-1:0]   channel_tolerance;
		logic [RATIO_W-1:0] max_diff_ratio_q16;
		logic [MEAN_W-1:0]  max_mean_error_q8;
	} icmp_cfg_t;

	// Running totals of one image, also the snapshot taken on the last pixel
	typedef struct packed {
		logic [CNT_W-1:0] diff_count;
		logic [ERR_W-1:0] abs_error;
		logic [PIX_W-1:0] max_delta;
		logic [CNT_W-1:0] pixel_count;
	} icmp_totals_t;

	// Result word, first field in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0]     pixels_seen;
		logic [ERR_OUT_W-1:0] error_sum;
		logic [PIX_W-1:0]     peak_channel_delta;
		logic [CNT_W-1:0]     differing_pixels;
		logic                 pass_flag;
		logic                 sizes_match;
	} icmp_result_t;

	localparam int RESULT_W = $bits(icmp_result_t);

endpackage
`default_nettype wire

// File: rtl/icmp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare channel lane
// Absolute difference of one channel byte pair and its tolerance test.
// ----------------------------------------------------------------------------
module icmp_lane
	import icmp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [PIX_W-1:0] exp_px,
	input  wire logic [PIX_W-1:0] act_px,
	input  wire logic [TOL_W-1:0] tolerance,
	output logic      [PIX_W-1:0] delta_s1,
	output logic                  over_s1
);

	logic [PIX_W-1:0] delta_c;

	always_comb begin
		if (exp_px >= act_px) begin
			delta_c = exp_px - act_px;
		end else begin
			delta_c = act_px - exp_px;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s1 <= delta_c;
			over_s1  <= (delta_c > tolerance);
		end
	end

endmodule
`default_nettype wire

// File: rtl/icmp_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare accumulator
// Merges the lane results of a pixel and folds them into the image totals.
// ----------------------------------------------------------------------------
module icmp_accum
	import icmp_pkg::*;
(
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              valid_s1,
	input  wire logic                              last_s1,
	input  wire logic [CHANNELS-1:0][PIX_W-1:0]    delta_s1,
	input  wire logic [CHANNELS-1:0]               over_s1,
	output logic                                   valid_s3,
	output icmp_totals_t                           totals_s3,
	output logic [1:0]                             pend
);

	logic [SUM_W-1:0] sum_c;
	logic [PIX_W-1:0] peak_c;
	logic             diff_c;

	logic [SUM_W-1:0] sum_s2;
	logic [PIX_W-1:0] peak_s2;
	logic             diff_s2;
	logic             valid_s2;
	logic             last_s2;

	icmp_totals_t     tot_q;
	icmp_totals_t     tot_nxt;
	logic [ERR_W:0]   err_ext;

	always_comb begin
		sum_c  = '0;
		peak_c = '0;
		diff_c = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			sum_c  = sum_c + SUM_W'(delta_s1[i]);
			peak_c = (delta_s1[i] > peak_c) ? delta_s1[i] : peak_c;
			diff_c = diff_c | over_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sum_s2  <= sum_c;
			peak_s2 <= peak_c;
			diff_s2 <= diff_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	// All three counters stick at their top value rather than wrap.
	always_comb begin
		err_ext = {1'b0, tot_q.abs_error} + (ERR_W + 1)'(sum_s2);
		tot_nxt = tot_q;
		tot_nxt.abs_error = err_ext[ERR_W] ? '1 : err_ext[ERR_W-1:0];
		if (diff_s2 && (tot_q.diff_count != '1)) begin
			tot_nxt.diff_count = tot_q.diff_count + 1'b1;
		end
		if (tot_q.pixel_count != '1) begin
			tot_nxt.pixel_count = tot_q.pixel_count + 1'b1;
		end
		if (peak_s2 > tot_q.max_delta) begin
			tot_nxt.max_delta = peak_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q    <= '0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 & last_s2;
			if (valid_s2) begin
				tot_q <= last_s2 ? '0 : tot_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2) begin
			totals_s3 <= tot_nxt;
		end
	end

	assign pend = {valid_s3, valid_s2 & last_s2};

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> (tot_q.pixel_count == '0))
		else $error("image totals not cleared after the last pixel");
`endif

endmodule
`default_nettype wire

// File: rtl/icmp_verdict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare verdict
// Area, threshold products and the pass decision for one image snapshot.
// ----------------------------------------------------------------------------
module icmp_verdict
	import icmp_pkg::*;
#(
	parameter int unsigned MAX_DIM = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         valid_s3,
	input  wire icmp_totals_t totals_s3,
	input  wire icmp_cfg_t    cfg,
	output logic              wr_en,
	output icmp_result_t      wr_data,
	output logic [1:0]        pend
);

	logic match_c;
	logic dims_ok_c;

	logic                valid_s4;
	icmp_totals_t        totals_s4;
	logic [AREA_W-1:0]   area_s4;
	logic                match_s4;
	logic                ok_s4;

	logic                    valid_s5;
	icmp_totals_t            totals_s5;
	logic [RATIO_PROD_W-1:0] rhs_ratio_s5;
	logic [MEAN_PROD_W-1:0]  rhs_err_s5;
	logic                    match_s5;
	logic                    ok_s5;

	logic [RATIO_PROD_W-1:0] lhs_ratio;
	logic [MEAN_PROD_W+1:0]  lhs_err;
	logic                    pass_c;

	assign match_c = (cfg.expected_width == cfg.actual_width) &&
			(cfg.expected_height == cfg.actual_height);
	assign dims_ok_c = (cfg.expected_width != '0) && (cfg.expected_height != '0) &&
			(32'(cfg.expected_width) <= 32'(MAX_DIM)) &&
			(32'(cfg.expected_height) <= 32'(MAX_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			totals_s4 <= totals_s3;
			area_s4   <= AREA_W'(cfg.expected_width) * AREA_W'(cfg.expected_height);
			match_s4  <= match_c;
			ok_s4     <= match_c & dims_ok_c;
		end
		if (valid_s4) begin
			totals_s5    <= totals_s4;
			rhs_ratio_s5 <= RATIO_PROD_W'(cfg.max_diff_ratio_q16) * RATIO_PROD_W'(area_s4);
			rhs_err_s5   <= MEAN_PROD_W'(cfg.max_mean_error_q8) * MEAN_PROD_W'(area_s4);
			match_s5     <= match_s4;
			ok_s5        <= ok_s4;
		end
	end

	// Both ratios are tested by cross-multiplying; the error side carries
	// the four channels as a shift by two.
	always_comb begin
		lhs_ratio = RATIO_PROD_W'({totals_s5.diff_count, {FRAC_RATIO_W{1'b0}}});
		lhs_err   = (MEAN_PROD_W + 2)'({totals_s5.abs_error, {FRAC_MEAN_W{1'b0}}});
		pass_c    = ok_s5 && (lhs_ratio <= rhs_ratio_s5) &&
				(lhs_err <= {rhs_err_s5, 2'b00});

		wr_data = '0;
		wr_data.sizes_match = match_s5;
		if (ok_s5) begin
			wr_data.pass_flag          = pass_c;
			wr_data.differing_pixels   = totals_s5.diff_count;
			wr_data.peak_channel_delta = totals_s5.max_delta;
			wr_data.error_sum          = totals_s5.abs_error[ERR_W-1] ? '1 :
					totals_s5.abs_error[ERR_OUT_W-1:0];
			wr_data.pixels_seen        = totals_s5.pixel_count;
		end
	end

	assign wr_en = valid_s5;
	assign pend  = {valid_s5, valid_s4};

`ifndef SYNTH
	a_pass_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data.pass_flag) |-> wr_data.sizes_match)
		else $error("pass flag raised on mismatched sizes");
`endif

endmodule
`default_nettype wire

// File: rtl/icmp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare result queue
// Small register queue holding finished result words for the output stream.
// ----------------------------------------------------------------------------
module icmp_fifo #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 82
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [WIDTH-1:0]            wr_data,
	input  wire logic                        rd_ready,
	output logic                             rd_valid,
	output logic [WIDTH-1:0]                 rd_data,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             rd_en;

	assign rd_valid = (count_q != '0);
	assign rd_en    = rd_valid & rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q != CW'(DEPTH)))
		else $error("result queue written while full");
`endif

endmodule
`default_nettype wire

// File: rtl/image_compare_statistics_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Image compare statistics core
// Compares an expected and an actual RGBA image pixel by pixel and reports
// error totals and a pass verdict at the end of each image.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on s_t* carries one pixel pair, s_tlast on the final pair
//   of an image. Four channel lanes take the absolute differences, an
//   accumulator folds them into the image totals, and on the last pixel the
//   verdict stage computes the area and threshold products and queues one
//   result word on m_t*. Other pixels produce no output.
//   Throughput is one pixel pair per cycle while s_tready is high. A result
//   word is visible on m_tvalid once it has passed, in order: the lane
//   differences registered at the edge that accepts its last pixel, then
//   merge, accumulate, area multiply, threshold multiply and finally the write into the result queue.
//   Results wait in a queue of FIFO_DEPTH words. s_tready drops only when the
//   words already queued plus the last pixels still in the pipeline fill the
//   queue, so the input keeps flowing while the receiver stalls until then.
//   Reset sets the dimensions to 1, other registers to 0, clears the totals
//   and empties the queue. Configuration writes on cfg_* take effect at once;
//   the user must make them only while no image is in flight, as the core has no check for it.
// ----------------------------------------------------------------------------
module image_compare_statistics_core
	import icmp_pkg::*;
#(
	parameter int unsigned MAX_DIM    = 1024,
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// exp_red, exp_green, exp_blue, exp_alpha, act_red, act_green, act_blue, act_alpha
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// sizes_match, pass_flag, differing_pixels, peak_channel_delta, error_sum,
	// pixels_seen, zero padding
	output logic [M_TDATA_W-1:0]       m_tdata
);

	localparam int QCW = $clog2(FIFO_DEPTH + 1);

	icmp_cfg_t cfg_q;

	logic accept;
	logic valid_s1;
	logic last_s1;

	logic [CHANNELS-1:0][PIX_W-1:0] delta_s1;
	logic [CHANNELS-1:0]            over_s1;

	logic         valid_s3;
	icmp_totals_t totals_s3;
	logic [1:0]   pend_acc;
	logic [1:0]   pend_ver;

	logic         res_wr;
	icmp_result_t res_data;
	logic [RESULT_W-1:0] q_data;
	logic [QCW-1:0]      q_count;
	logic [2:0]          inflight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_width     <= DIM_W'(1);
			cfg_q.expected_height    <= DIM_W'(1);
			cfg_q.actual_width       <= DIM_W'(1);
			cfg_q.actual_height      <= DIM_W'(1);
			cfg_q.channel_tolerance  <= '0;
			cfg_q.max_diff_ratio_q16 <= '0;
			cfg_q.max_mean_error_q8  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXP_WIDTH:  cfg_q.expected_width     <= cfg_data[DIM_W-1:0];
				CFG_EXP_HEIGHT: cfg_q.expected_height    <= cfg_data[DIM_W-1:0];
				CFG_ACT_WIDTH:  cfg_q.actual_width       <= cfg_data[DIM_W-1:0];
				CFG_ACT_HEIGHT: cfg_q.actual_height      <= cfg_data[DIM_W-1:0];
				CFG_TOLERANCE:  cfg_q.channel_tolerance  <= cfg_data[TOL_W-1:0];
				CFG_MAX_RATIO:  cfg_q.max_diff_ratio_q16 <= cfg_data[RATIO_W-1:0];
				CFG_MAX_MEAN:   cfg_q.max_mean_error_q8  <= cfg_data[MEAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Every last pixel still in the pipeline holds a reserved queue slot.
	always_comb begin
		inflight = '0;
		inflight = inflight + 3'(valid_s1 & last_s1);
		inflight = inflight + 3'(pend_acc[0]) + 3'(pend_acc[1]);
		inflight = inflight + 3'(pend_ver[0]) + 3'(pend_ver[1]);
	end

	assign s_tready = (32'(q_count) + 32'(inflight)) < 32'(FIFO_DEPTH);
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			last_s1  <= s_tlast;
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		icmp_lane u_lane (
			.clk       (clk),
			.en        (accept),
			.exp_px    (s_tdata[g*PIX_W +: PIX_W]),
			.act_px    (s_tdata[(CHANNELS + g)*PIX_W +: PIX_W]),
			.tolerance (cfg_q.channel_tolerance),
			.delta_s1  (delta_s1[g]),
			.over_s1   (over_s1[g])
		);
	end

	icmp_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.last_s1   (last_s1),
		.delta_s1  (delta_s1),
		.over_s1   (over_s1),
		.valid_s3  (valid_s3),
		.totals_s3 (totals_s3),
		.pend      (pend_acc)
	);

	icmp_verdict #(
		.MAX_DIM (MAX_DIM)
	) u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.totals_s3 (totals_s3),
		.cfg       (cfg_q),
		.wr_en     (res_wr),
		.wr_data   (res_data),
		.pend      (pend_ver)
	);

	icmp_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (RESULT_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_wr),
		.wr_data  (res_data),
		.rd_ready (m_tready),
		.rd_valid (m_tvalid),
		.rd_data  (q_data),
		.count    (q_count)
	);

	assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, q_data};

`ifndef SYNTH
	a_queue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(q_count) + 32'(inflight)) <= 32'(FIFO_DEPTH))
		else $error("more results in flight than queue slots");
`endif

endmodule
`default_nettype wire

// File: tb/tb_image_compare_statistics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the image compare statistics core
// Streams pixel pairs into the core under several configurations and flow
// patterns. Every result word is checked field by field against a fixed word or
// a predictor that folds each accepted pixel pair into its own copy of the image totals.
// ----------------------------------------------------------------------------
module tb_image_compare_statistics_core;
	import icmp_pkg::*;

	localparam int unsigned DIM_LIMIT   = 1024;
	localparam int unsigned CNT_SAT     = 32'h001F_FFFF;
	localparam int unsigned ERR_SAT     = 32'h7FFF_FFFF;
	localparam int unsigned ERR_OUT_SAT = 32'h3FFF_FFFF;
	localparam int          SETTLE      = 12;
	localparam int          PHASE_ITEMS = 116;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

	typedef struct {
		int          preset;
		logic [31:0] exp_rgba;
		logic [31:0] act_rgba;
		bit          last;
		bit          typed;
		icmp_result_t want;
	} row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	image_compare_statistics_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predictor state: register copy and running image totals.
	icmp_cfg_t       regs;
	int unsigned     acc_diff, acc_err, acc_peak, acc_pixels;
	icmp_result_t    pending_results[$];
	flow_t           flow = FLOW_FREE;
	bit              hold_request = 1'b0;
	int              failures = 0;
	row_t            rows[$];
	icmp_cfg_t       presets[7];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_image_compare_statistics_core NOT OK");
		$finish;
	end

	function automatic icmp_result_t outcome(bit m, bit p, int unsigned d, int unsigned pk,
			int unsigned e, int unsigned s);
		icmp_result_t r;
		r.sizes_match        = m;
		r.pass_flag          = p;
		r.differing_pixels   = CNT_W'(d);
		r.peak_channel_delta = PIX_W'(pk);
		r.error_sum          = ERR_OUT_W'(e);
		r.pixels_seen        = CNT_W'(s);
		return r;
	endfunction

	function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_EXP_WIDTH:  regs.expected_width     = d[DIM_W-1:0];
			CFG_EXP_HEIGHT: regs.expected_height    = d[DIM_W-1:0];
			CFG_ACT_WIDTH:  regs.actual_width       = d[DIM_W-1:0];
			CFG_ACT_HEIGHT: regs.actual_height      = d[DIM_W-1:0];
			CFG_TOLERANCE:  regs.channel_tolerance  = d[TOL_W-1:0];
			CFG_MAX_RATIO:  regs.max_diff_ratio_q16 = d[RATIO_W-1:0];
			CFG_MAX_MEAN:   regs.max_mean_error_q8  = d[MEAN_W-1:0];
			default: ;
		endcase
	endfunction

	// Folds one pixel pair into the totals; on the last pixel it yields the
	// result word and clears the totals.
	function automatic bit fold_pixel(logic [S_TDATA_W-1:0] d, bit last,
			output icmp_result_t r);
		int unsigned e, a, dd, sum;
		bit differs, match, valid;
		longint unsigned area;
		sum = 0;
		differs = 0;
		r = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			e = 32'(d[c*PIX_W +: PIX_W]);
			a = 32'(d[(c+CHANNELS)*PIX_W +: PIX_W]);
			dd = (e >= a) ? e - a : a - e;
			sum += dd;
			if (dd > acc_peak)
				acc_peak = dd;
			if (dd > regs.channel_tolerance)
				differs = 1;
		end
		if (longint'(acc_err) + sum > ERR_SAT)
			acc_err = ERR_SAT;
		else
			acc_err += sum;
		if (differs && acc_diff < CNT_SAT)
			acc_diff++;
		if (acc_pixels < CNT_SAT)
			acc_pixels++;
		if (!last)
			return 0;
		match = regs.expected_width == regs.actual_width &&
			regs.expected_height == regs.actual_height;
		valid = regs.expected_width != 0 && regs.expected_height != 0 &&
			regs.expected_width <= DIM_LIMIT && regs.expected_height <= DIM_LIMIT;
		r.sizes_match = match;
		if (match && valid) begin
			area = longint'(regs.expected_width) * regs.expected_height;
			r.pass_flag = ((longint'(acc_diff) << FRAC_RATIO_W) <=
					longint'(regs.max_diff_ratio_q16) * area) &&
				((longint'(acc_err) << FRAC_MEAN_W) <=
					longint'(regs.max_mean_error_q8) * CHANNELS * area);
			r.differing_pixels   = CNT_W'(acc_diff);
			r.peak_channel_delta = PIX_W'(acc_peak);
			r.error_sum          = ERR_OUT_W'((acc_err > ERR_OUT_SAT) ? ERR_OUT_SAT : acc_err);
			r.pixels_seen        = CNT_W'(acc_pixels);
		end
		acc_diff = 0;
		acc_err = 0;
		acc_peak = 0;
		acc_pixels = 0;
		return 1;
	endfunction

	// Puts random junk above the register's width; the core must drop it.
	function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int w, bit junk);
		int unsigned mask;
		mask = (32'd1 << w) - 1;
		return CFG_DATA_W'(junk ? ((v & mask) | ($urandom & ~mask)) : v);
	endfunction

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		store_reg(idx, d);
	endtask

	task automatic apply_cfg(icmp_cfg_t c, bit junk);
		put_reg(CFG_EXP_WIDTH,  with_junk(c.expected_width, DIM_W, junk));
		put_reg(CFG_EXP_HEIGHT, with_junk(c.expected_height, DIM_W, junk));
		put_reg(CFG_ACT_WIDTH,  with_junk(c.actual_width, DIM_W, junk));
		put_reg(CFG_ACT_HEIGHT, with_junk(c.actual_height, DIM_W, junk));
		put_reg(CFG_TOLERANCE,  with_junk(c.channel_tolerance, TOL_W, junk));
		put_reg(CFG_MAX_RATIO,  with_junk(c.max_diff_ratio_q16, RATIO_W, junk));
		put_reg(CFG_MAX_MEAN,   with_junk(c.max_mean_error_q8, MEAN_W, junk));
		put_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Waits until every expected word has arrived and the pipeline is empty.
	task automatic settle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic bit sender_idles();
		case (flow)
			FLOW_SRC_IDLE: return $urandom_range(99) < 83;
			FLOW_BOTH:     return $urandom_range(99) < 11;
			default:       return 0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (flow)
			FLOW_SINK_STALL: return $urandom_range(99) < 83;
			FLOW_BOTH:       return $urandom_range(99) < 11;
			default:         return 0;
		endcase
	endfunction

	// Offers one word and returns at the edge where it is taken.
	task automatic send_pixel(logic [S_TDATA_W-1:0] d, bit last, bit typed,
			icmp_result_t want);
		icmp_result_t r;
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (fold_pixel(d, last, r))
			pending_results.push_back(typed ? want : r);
	endtask

	function automatic logic [S_TDATA_W-1:0] random_pair(int unsigned tol);
		logic [S_TDATA_W-1:0] d;
		int unsigned style, e, dd;
		int a;
		d = {$urandom, $urandom};
		style = $urandom_range(0, 9);
		if (style == 4) begin
			d[S_TDATA_W-1:S_TDATA_W/2] = d[S_TDATA_W/2-1:0];
		end else if (style == 7) begin
			for (int c = 0; c < 2*CHANNELS; c++)
				d[c*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (style != 5 && style != 6) begin
			// Actual channels close to the expected ones: within two, or around the tolerance.
			for (int c = 0; c < CHANNELS; c++) begin
				e  = 32'(d[c*PIX_W +: PIX_W]);
				dd = $urandom_range(0, (style >= 8) ? 2 : tol + 2);
				a  = $urandom_range(0, 1) ? int'(e) + int'(dd) : int'(e) - int'(dd);
				if (a < 0)
					a = 0;
				if (a > 255)
					a = 255;
				d[(c+CHANNELS)*PIX_W +: PIX_W] = PIX_W'(a);
			end
		end
		return d;
	endfunction

	function automatic icmp_cfg_t random_cfg();
		icmp_cfg_t c;
		int unsigned kind, w, h;
		kind = $urandom_range(0, 9);
		w = $urandom_range(1, 8);
		h = $urandom_range(1, 8);
		if (kind == 8) begin
			w = $urandom_range(1, DIM_LIMIT);
			h = $urandom_range(1, DIM_LIMIT);
		end else if (kind == 1) begin
			if ($urandom_range(0, 1)) begin
				w = $urandom_range(0, 1) ? 0 : w;
				h = (w == 0) ? h : 0;
			end else begin
				w = $urandom_range(DIM_LIMIT + 1, 2047);
			end
		end
		c.expected_width  = DIM_W'(w);
		c.expected_height = DIM_W'(h);
		c.actual_width    = DIM_W'(w);
		c.actual_height   = DIM_W'(h);
		if (kind == 0) begin
			if ($urandom_range(0, 1))
				c.actual_width = DIM_W'(w + $urandom_range(1, 3));
			else
				c.actual_height = DIM_W'(h + $urandom_range(1, 3));
		end
		c.channel_tolerance = TOL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, 24));
		case ($urandom_range(0, 3))
			0:       c.max_diff_ratio_q16 = '0;
			1:       c.max_diff_ratio_q16 = RATIO_W'(65536);
			default: c.max_diff_ratio_q16 = RATIO_W'($urandom_range(0, 65536));
		endcase
		c.max_mean_error_q8 = MEAN_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 65280)
			: $urandom_range(0, 16'h1800));
		return c;
	endfunction

	task automatic add_row(int preset, logic [31:0] e, logic [31:0] a, bit last,
			bit typed, icmp_result_t want);
		row_t r;
		r.preset   = preset;
		r.exp_rgba = e;
		r.act_rgba = a;
		r.last     = last;
		r.typed    = typed;
		r.want     = want;
		rows.push_back(r);
	endtask

	// Result side: ready pattern, with the long hold-off counted here.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !receiver_stalls();
			end
		end
	end

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	initial begin
		icmp_result_t want, got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata[RESULT_W-1:0];
				if (pending_results.size() == 0) begin
					$error("result word with no image pending: %h", m_tdata);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("sizes_match", want.sizes_match, got.sizes_match);
					check_field("pass_flag", want.pass_flag, got.pass_flag);
					check_field("differing_pixels", want.differing_pixels,
						got.differing_pixels);
					check_field("peak_channel_delta", want.peak_channel_delta,
						got.peak_channel_delta);
					check_field("error_sum", want.error_sum, got.error_sum);
					check_field("pixels_seen", want.pixels_seen, got.pixels_seen);
					check_field("padding", 0, m_tdata[M_TDATA_W-1:RESULT_W]);
				end
			end
		end
	end

	initial begin
		icmp_cfg_t c;
		icmp_result_t none;
		int cur_preset, sent, len;
		longint unsigned area;

		none = '0;
		regs = '0;
		regs.expected_width  = 1;
		regs.expected_height = 1;
		regs.actual_width    = 1;
		regs.actual_height   = 1;
		acc_diff = 0;
		acc_err = 0;
		acc_peak = 0;
		acc_pixels = 0;

		// Preset 0 holds the reset values and is in force without any write.
		presets[0] = regs;
		presets[1] = '{4, 4, 4, 5, 10, 65536, 65280};
		presets[2] = '{0, 0, 0, 0, 0, 65536, 65280};
		presets[3] = '{1025, 2047, 1025, 2047, 0, 65536, 65280};
		presets[4] = '{1024, 1024, 1024, 1024, 255, 65536, 65280};
		presets[5] = '{2, 2, 2, 2, 16, 32768, 16'h1000};
		presets[6] = '{4, 4, 5, 4, 0, 0, 0};

		add_row(0, 32'h0000_0000, 32'h0000_0000, 1, 1, outcome(1, 1, 0, 0, 0, 1));
		add_row(0, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, outcome(1, 0, 1, 255, 1020, 1));
		add_row(0, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, outcome(1, 0, 1, 255, 1020, 1));
		add_row(0, 32'h0000_0080, 32'h0000_007F, 1, 1, outcome(1, 0, 1, 1, 1, 1));
		add_row(0, 32'h1234_5678, 32'h8765_4321, 0, 0, none);
		add_row(0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0, none);
		add_row(0, 32'h0102_0304, 32'h0102_0304, 1, 0, none);
		add_row(1, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, none);
		add_row(1, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, outcome(0, 0, 0, 0, 0, 0));
		add_row(2, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, outcome(1, 0, 0, 0, 0, 0));
		add_row(3, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, outcome(1, 0, 0, 0, 0, 0));
		add_row(4, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, outcome(1, 1, 0, 255, 1020, 1));
		add_row(5, 32'h1010_1010, 32'h2010_1010, 0, 0, none);
		add_row(5, 32'h0000_0000, 32'h1100_0000, 0, 0, none);
		add_row(5, 32'h8080_8080, 32'h7F81_7F81, 0, 0, none);
		add_row(5, 32'h0000_0000, 32'h0000_0000, 1, 0, none);
		add_row(5, 32'h00FF_00FF, 32'hFF00_FF00, 1, 0, none);
		add_row(6, 32'h0000_0000, 32'h0000_0001, 1, 1, outcome(0, 0, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_preset = 0;
		foreach (rows[i]) begin
			if (rows[i].preset != cur_preset) begin
				s_tvalid <= 1'b0;
				settle();
				apply_cfg(presets[rows[i].preset], rows[i].preset == 3);
				cur_preset = rows[i].preset;
			end
			send_pixel({rows[i].act_rgba, rows[i].exp_rgba}, rows[i].last,
				rows[i].typed, rows[i].want);
		end
		s_tvalid <= 1'b0;
		settle();

		// Hold the result side off while single-pixel images keep arriving,
		// so the result queue fills and the core has to refuse input.
		apply_cfg(presets[5], 0);
		hold_request = 1;
		for (int i = 0; i < 60; i++)
			send_pixel(random_pair(regs.channel_tolerance), 1, 0, none);
		s_tvalid <= 1'b0;
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			flow = flow_t'(ph % 4);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent == 0 || $urandom_range(0, 3) == 0) begin
					s_tvalid <= 1'b0;
					settle();
					c = random_cfg();
					apply_cfg(c, $urandom_range(0, 3) == 0);
				end
				area = longint'(regs.expected_width) * regs.expected_height;
				if (area != 0 && area <= 64 && $urandom_range(0, 4) != 0)
					len = int'(area);
				else
					len = $urandom_range(1, 48);
				for (int k = 0; k < len; k++)
					send_pixel(random_pair(regs.channel_tolerance), k == len - 1, 0, none);
				sent += len;
			end
		end
		s_tvalid <= 1'b0;
		flow = FLOW_FREE;
		settle();

		if (failures == 0 && pending_results.size() == 0) begin
			$display("tb_image_compare_statistics_core OK");
		end else begin
			$display("tb_image_compare_statistics_core NOT OK");
		end
		$finish;
	end

endmodule
